// ----- rtl/psdt_pkg.sv -----
// ----------------------------------------------------------------------------
// Pulse sequence descriptor table package
// Shared types, codes and default sizes for the descriptor table core.
// ----------------------------------------------------------------------------
package psdt_pkg;

   // Default table sizes.
   localparam int DEF_ENTRIES    = 16;
   localparam int DEF_MAX_PULSES = 16;

   // Width of the delivered element count carried with a command.
   localparam int CNT_W = 7;

   // Transaction operation codes.
   typedef enum logic [1:0] {
      ACT_ADD    = 2'd0,
      ACT_CHECK  = 2'd1,
      ACT_REMOVE = 2'd2,
      ACT_NONE   = 2'd3
   } action_type;

   // Result status codes.
   typedef enum logic [1:0] {
      ST_OK       = 2'd0,
      ST_NO_MATCH = 2'd1,
      ST_FULL     = 2'd2,
      ST_UNUSED   = 2'd3
   } status_type;

   // Back end sequencer states.
   typedef enum logic [2:0] {
      BK_IDLE,
      BK_ADD_WR,
      BK_CHK_SLOT,
      BK_CHK_HDR,
      BK_CHK_PAT
   } back_state_type;

   // Input transaction.
   typedef struct packed {
      logic [1:0]  action;
      logic [9:0]  range_count;
      logic [11:0] first_range;
      logic [9:0]  range_sep;
      logic [4:0]  pulse_count;
      logic [15:0] pulse_increment;
      logic [7:0]  baud_count;
      logic [7:0]  pulse_pos;
      logic        last;
      logic [3:0]  slot;
   } req_type;

   // Result transaction.
   typedef struct packed {
      logic [1:0] status;
      logic [3:0] slot_out;
   } rsp_type;

   // Packed descriptor header, 61 bits.
   typedef struct packed {
      logic [7:0]  baud_count;
      logic [15:0] pulse_increment;
      logic [4:0]  pulse_count;
      logic [9:0]  range_sep;
      logic [11:0] first_range;
      logic [9:0]  range_count;
   } hdr_type;

   // Command passed from the front end to the back end.
   typedef struct packed {
      action_type       action;
      hdr_type          header;
      logic [CNT_W-1:0] count;
      logic [3:0]       slot;
   } cmd_type;

   // Queue status seen by the core top level and the back end.
   typedef struct packed {
      logic empty;
      logic full;
   } q_status_type;

endpackage

// ----- rtl/pulse_sequence_descriptor_table_core.sv -----
// ----------------------------------------------------------------------------
// Pulse sequence descriptor table core
// Sequencing: a remove gives no result; an add writes the header and then
// the pattern, one element a cycle, and gives its result after the last
// element; a check walks the slots from the mark down, skipping inactive
// slots, reading each active header and comparing elements on a match.
// Throughput: one command at a time; busy stays high until it is done.
// The receiver cannot stall; each result strobe lasts exactly one cycle.
// Reset clears the active slots, the mark and the element count at once.
// ----------------------------------------------------------------------------
module pulse_sequence_descriptor_table_core #(
   parameter int ENTRIES    = psdt_pkg::DEF_ENTRIES,
   parameter int MAX_PULSES = psdt_pkg::DEF_MAX_PULSES
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  psdt_pkg::req_type  req_data,
   output logic               rsp_valid,
   output psdt_pkg::rsp_type  rsp_data
);
   import psdt_pkg::*;

   logic                        accept;
   logic                        push;
   logic                        pop;
   logic                        back_busy;
   cmd_type                     push_cmd;
   cmd_type                     pop_cmd;
   q_status_type                q_status;
   logic [MAX_PULSES-1:0][7:0]  staging;

   // A transaction is taken only while the queue and the back end are empty.
   assign busy   = !q_status.empty || back_busy;
   assign accept = start && !busy;

   psdt_front #(
      .MAX_PULSES (MAX_PULSES)
   ) u_front (
      .clock   (clock),
      .reset   (reset),
      .accept  (accept),
      .req     (req_data),
      .push    (push),
      .cmd     (push_cmd),
      .staging (staging)
   );

   psdt_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_cmd),
      .pop       (pop),
      .pop_data  (pop_cmd),
      .q_status  (q_status)
   );

   psdt_back #(
      .ENTRIES    (ENTRIES),
      .MAX_PULSES (MAX_PULSES)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .q_status  (q_status),
      .cmd       (pop_cmd),
      .staging   (staging),
      .pop       (pop),
      .back_busy (back_busy),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

endmodule

// ----- rtl/psdt_front.sv -----
// ----------------------------------------------------------------------------
// Descriptor table front end
// Accepts transactions, stages pattern elements and issues commands.
// ----------------------------------------------------------------------------
module psdt_front #(
   parameter int MAX_PULSES = psdt_pkg::DEF_MAX_PULSES
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           accept,
   input  psdt_pkg::req_type              req,
   output logic                           push,
   output psdt_pkg::cmd_type              cmd,
   output logic [MAX_PULSES-1:0][7:0]     staging
);
   import psdt_pkg::*;

   localparam int KW  = $clog2(MAX_PULSES + 1);
   localparam int SIW = (MAX_PULSES > 1) ? $clog2(MAX_PULSES) : 1;

   logic [KW-1:0]                count_ff, count_in;
   logic [MAX_PULSES-1:0][7:0]   staging_ff;
   logic                         is_run;
   logic                         take_elem;

   // An add or check item carries one pattern element.
   assign is_run    = (req.action == ACT_ADD) || (req.action == ACT_CHECK);
   assign take_elem = accept && is_run && (int'(count_ff) < MAX_PULSES);

   // A command leaves on a remove or on the final item of a run.
   assign push = accept && ((req.action == ACT_REMOVE) || (is_run && req.last));

   always_comb begin
      cmd.action                 = action_type'(req.action);
      cmd.header.baud_count      = req.baud_count;
      cmd.header.pulse_increment = req.pulse_increment;
      cmd.header.pulse_count     = req.pulse_count;
      cmd.header.range_sep       = req.range_sep;
      cmd.header.first_range     = req.first_range;
      cmd.header.range_count     = req.range_count;
      cmd.count                  = CNT_W'(count_ff) + CNT_W'(take_elem);
      cmd.slot                   = req.slot;
   end

   // Element counter: clears on completion of a run.
   always_comb begin
      count_in = count_ff;
      if (accept && is_run) begin
         if (req.last) begin
            count_in = '0;
         end else if (take_elem) begin
            count_in = count_ff + KW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   // Staging register for the pattern elements.
   always_ff @(posedge clock) begin
      if (take_elem) begin
         staging_ff[count_ff[SIW-1:0]] <= req.pulse_pos;
      end
   end

   assign staging = staging_ff;

endmodule

// ----- rtl/psdt_queue.sv -----
// ----------------------------------------------------------------------------
// Descriptor table command queue
// Two-entry queue between the front end and the back end.
// ----------------------------------------------------------------------------
module psdt_queue (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    push,
   input  psdt_pkg::cmd_type       push_data,
   input  logic                    pop,
   output psdt_pkg::cmd_type       pop_data,
   output psdt_pkg::q_status_type  q_status
);
   import psdt_pkg::*;

   cmd_type    mem_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] fill_ff, fill_in;
   logic       do_push, do_pop;

   assign do_push = push && (fill_ff != 2'd2);
   assign do_pop  = pop && (fill_ff != 2'd0);

   // Pointer and fill level update.
   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ do_push;
      rd_ptr_in = rd_ptr_ff ^ do_pop;
      fill_in   = fill_ff + 2'(do_push) - 2'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         fill_ff   <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   // Storage for the queued commands.
   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign pop_data       = mem_ff[rd_ptr_ff];
   assign q_status.empty = (fill_ff == 2'd0);
   assign q_status.full  = (fill_ff == 2'd2);

endmodule

// ----- rtl/psdt_back.sv -----
// ----------------------------------------------------------------------------
// Descriptor table back end
// Holds the table and carries out add, check and remove commands.
// ----------------------------------------------------------------------------
module psdt_back #(
   parameter int ENTRIES    = psdt_pkg::DEF_ENTRIES,
   parameter int MAX_PULSES = psdt_pkg::DEF_MAX_PULSES
) (
   input  logic                        clock,
   input  logic                        reset,
   input  psdt_pkg::q_status_type      q_status,
   input  psdt_pkg::cmd_type           cmd,
   input  logic [MAX_PULSES-1:0][7:0]  staging,
   output logic                        pop,
   output logic                        back_busy,
   output logic                        rsp_valid,
   output psdt_pkg::rsp_type           rsp_data
);
   import psdt_pkg::*;

   localparam int SW  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int HW  = $clog2(ENTRIES + 1);
   localparam int KW  = $clog2(MAX_PULSES + 1);
   localparam int SIW = (MAX_PULSES > 1) ? $clog2(MAX_PULSES) : 1;
   localparam int AW  = (ENTRIES * MAX_PULSES > 1) ? $clog2(ENTRIES * MAX_PULSES) : 1;

   back_state_type      state_ff, state_in;
   cmd_type             cmd_ff, cmd_in;
   logic [ENTRIES-1:0]  active_ff, active_in;
   logic [HW-1:0]       hw_ff, hw_in;
   logic [HW-1:0]       idx_ff, idx_in;
   logic [SW-1:0]       slot_ff, slot_in;
   logic [KW-1:0]       k_ff, k_in;
   logic                rsp_valid_ff, rsp_valid_in;
   rsp_type             rsp_ff, rsp_in;

   hdr_type             hdr_mem [ENTRIES];
   logic [7:0]          pat_mem [ENTRIES * MAX_PULSES];
   hdr_type             hdr_rd_ff;
   logic [7:0]          pat_rd_ff;

   logic                hdr_we, hdr_re, pat_we, pat_re;
   logic [SW-1:0]       hdr_addr;
   logic [AW-1:0]       pat_waddr, pat_raddr;
   logic [7:0]          pat_wdata;

   logic [KW-1:0]       plen;
   logic [SW-1:0]       free_slot;
   logic [SW-1:0]       scan_slot;
   logic [SW-1:0]       rm_slot;
   logic [7:0]          stage_val;

   // Pattern length: pulse count limited to the pattern capacity.
   assign plen = (int'(cmd_ff.header.pulse_count) > MAX_PULSES) ?
                 KW'(MAX_PULSES) : KW'(cmd_ff.header.pulse_count);

   // Staged element at position k, zero beyond the delivered elements.
   assign stage_val = (CNT_W'(k_ff) < cmd_ff.count) ? staging[k_ff[SIW-1:0]] : 8'd0;

   // Lowest inactive slot below the mark, else the mark itself.
   always_comb begin
      free_slot = SW'(hw_ff);
      for (int i = ENTRIES - 1; i >= 0; i--) begin
         if ((i < int'(hw_ff)) && !active_ff[i]) begin
            free_slot = SW'(i);
         end
      end
   end

   assign scan_slot = SW'(idx_ff - HW'(1));
   assign rm_slot   = SW'(cmd.slot);

   // Sequencer: next state, table updates and results.
   always_comb begin
      state_in     = state_ff;
      cmd_in       = cmd_ff;
      active_in    = active_ff;
      hw_in        = hw_ff;
      idx_in       = idx_ff;
      slot_in      = slot_ff;
      k_in         = k_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;
      pop          = 1'b0;
      hdr_we       = 1'b0;
      hdr_re       = 1'b0;
      hdr_addr     = slot_ff;
      pat_we       = 1'b0;
      pat_re       = 1'b0;
      pat_waddr    = AW'(slot_ff) * AW'(MAX_PULSES) + AW'(k_ff);
      pat_raddr    = AW'(slot_ff) * AW'(MAX_PULSES) + AW'(k_ff);
      pat_wdata    = ((k_ff < plen) ? stage_val : 8'd0);

      unique case (state_ff)
         BK_IDLE: begin
            if (!q_status.empty) begin
               pop    = 1'b1;
               cmd_in = cmd;
               unique case (cmd.action)
                  ACT_REMOVE: begin
                     if ((hw_ff != '0) && (int'(cmd.slot) < ENTRIES)) begin
                        if (HW'(rm_slot) == hw_ff - HW'(1)) begin
                           hw_in = hw_ff - HW'(1);
                        end
                        active_in[rm_slot] = 1'b0;
                     end
                  end
                  ACT_ADD: begin
                     if (int'(hw_ff) >= ENTRIES) begin
                        rsp_valid_in    = 1'b1;
                        rsp_in.status   = ST_FULL;
                        rsp_in.slot_out = '0;
                     end else begin
                        active_in[free_slot] = 1'b1;
                        if (HW'(free_slot) == hw_ff) begin
                           hw_in = hw_ff + HW'(1);
                        end
                        hdr_we   = 1'b1;
                        hdr_addr = free_slot;
                        slot_in  = free_slot;
                        k_in     = '0;
                        state_in = BK_ADD_WR;
                     end
                  end
                  ACT_CHECK: begin
                     idx_in   = hw_ff;
                     state_in = BK_CHK_SLOT;
                  end
                  default: begin
                  end
               endcase
            end
         end
         BK_ADD_WR: begin
            // One pattern position written per cycle.
            pat_we = 1'b1;
            if (int'(k_ff) == MAX_PULSES - 1) begin
               rsp_valid_in    = 1'b1;
               rsp_in.status   = ST_OK;
               rsp_in.slot_out = 4'(slot_ff);
               state_in        = BK_IDLE;
            end else begin
               k_in = k_ff + KW'(1);
            end
         end
         BK_CHK_SLOT: begin
            // Walk downwards from the mark; read the header of an active slot.
            if (idx_ff == '0) begin
               rsp_valid_in    = 1'b1;
               rsp_in.status   = ST_NO_MATCH;
               rsp_in.slot_out = '0;
               state_in        = BK_IDLE;
            end else if (active_ff[scan_slot]) begin
               hdr_re   = 1'b1;
               hdr_addr = scan_slot;
               slot_in  = scan_slot;
               state_in = BK_CHK_HDR;
            end else begin
               idx_in = idx_ff - HW'(1);
            end
         end
         BK_CHK_HDR: begin
            if (hdr_rd_ff != cmd_ff.header) begin
               idx_in   = idx_ff - HW'(1);
               state_in = BK_CHK_SLOT;
            end else if (plen == '0) begin
               rsp_valid_in    = 1'b1;
               rsp_in.status   = ST_OK;
               rsp_in.slot_out = 4'(slot_ff);
               state_in        = BK_IDLE;
            end else begin
               k_in      = '0;
               pat_re    = 1'b1;
               pat_raddr = AW'(slot_ff) * AW'(MAX_PULSES);
               state_in  = BK_CHK_PAT;
            end
         end
         BK_CHK_PAT: begin
            if (pat_rd_ff != stage_val) begin
               idx_in   = idx_ff - HW'(1);
               state_in = BK_CHK_SLOT;
            end else if (k_ff == plen - KW'(1)) begin
               rsp_valid_in    = 1'b1;
               rsp_in.status   = ST_OK;
               rsp_in.slot_out = 4'(slot_ff);
               state_in        = BK_IDLE;
            end else begin
               k_in      = k_ff + KW'(1);
               pat_re    = 1'b1;
               pat_raddr = AW'(slot_ff) * AW'(MAX_PULSES) + AW'(k_ff) + AW'(1);
            end
         end
         default: begin
            state_in = BK_IDLE;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         active_ff    <= '0;
         hw_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         active_ff    <= active_in;
         hw_ff        <= hw_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Working registers.
   always_ff @(posedge clock) begin
      cmd_ff  <= cmd_in;
      idx_ff  <= idx_in;
      slot_ff <= slot_in;
      k_ff    <= k_in;
      rsp_ff  <= rsp_in;
   end

   // Header memory with registered read.
   always_ff @(posedge clock) begin
      if (hdr_we) begin
         hdr_mem[hdr_addr] <= cmd.header;
      end
      if (hdr_re) begin
         hdr_rd_ff <= hdr_mem[hdr_addr];
      end
   end

   // Pattern memory with registered read.
   always_ff @(posedge clock) begin
      if (pat_we) begin
         pat_mem[pat_waddr] <= pat_wdata;
      end
      if (pat_re) begin
         pat_rd_ff <= pat_mem[pat_raddr];
      end
   end

   assign back_busy = (state_ff != BK_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

// ----- rtl/psdt_checker.sv -----
// ----------------------------------------------------------------------------
// Descriptor table port checker
// Checks on the top level ports over time, bound to the core.
// ----------------------------------------------------------------------------
module psdt_checker (
   input logic               clock,
   input logic               reset,
   input logic               start,
   input logic               busy,
   input psdt_pkg::req_type  req_data,
   input logic               rsp_valid,
   input psdt_pkg::rsp_type  rsp_data
);
   import psdt_pkg::*;

   // No result in the cycle after reset.
   a_no_rsp_after_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result straight after reset");

   // A failed operation reports slot zero.
   a_fail_slot_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_data.status != ST_OK)) |-> (rsp_data.slot_out == '0))
      else $error("failed operation with non-zero slot");

   // The unused status code never appears.
   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.status != ST_UNUSED))
      else $error("unused status code");

   // A remove transaction keeps the block busy on the next cycle.
   a_remove_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && (req_data.action == ACT_REMOVE)) |=> busy)
      else $error("remove not taken up");

endmodule

bind pulse_sequence_descriptor_table_core psdt_checker u_psdt_checker (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .busy      (busy),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_data  (rsp_data)
);
